// ===== rtl/core/tkd_pkg.sv =====
// Shared types and constants of the terminal key event decoder.
// Holds the parse phase enumeration, byte and key code constants and the queue entry type.
// No dependencies.
package tkd_pkg;

	localparam int TIME_WIDTH_DEF  = 32;
	localparam int STAMP_WIDTH     = 32;
	localparam int GAP_WIDTH       = 32;
	localparam logic [GAP_WIDTH-1:0] RELEASE_GAP_RST = 32'd250;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ESC,
		PH_CSI,
		PH_CSI1,
		PH_CSI2,
		PH_SS3,
		PH_SWALLOW
	} phase_t;

	// Input characters.
	localparam logic [7:0] CH_ESC      = 8'h1b;
	localparam logic [7:0] CH_LBRACKET = 8'h5b;
	localparam logic [7:0] CH_UPPER_O  = 8'h4f;
	localparam logic [7:0] CH_UPPER_A  = 8'h41;
	localparam logic [7:0] CH_UPPER_B  = 8'h42;
	localparam logic [7:0] CH_UPPER_C  = 8'h43;
	localparam logic [7:0] CH_UPPER_D  = 8'h44;
	localparam logic [7:0] CH_UPPER_P  = 8'h50;
	localparam logic [7:0] CH_UPPER_S  = 8'h53;
	localparam logic [7:0] CH_UPPER_Z  = 8'h5a;
	localparam logic [7:0] CH_LOWER_A  = 8'h61;
	localparam logic [7:0] CH_LOWER_P  = 8'h70;
	localparam logic [7:0] CH_LOWER_Z  = 8'h7a;
	localparam logic [7:0] CH_DIGIT_0  = 8'h30;
	localparam logic [7:0] CH_DIGIT_1  = 8'h31;
	localparam logic [7:0] CH_DIGIT_2  = 8'h32;
	localparam logic [7:0] CH_DIGIT_4  = 8'h34;
	localparam logic [7:0] CH_DIGIT_5  = 8'h35;
	localparam logic [7:0] CH_DIGIT_7  = 8'h37;
	localparam logic [7:0] CH_DIGIT_8  = 8'h38;
	localparam logic [7:0] CH_DIGIT_9  = 8'h39;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	// Key codes.
	localparam logic [7:0] KEY_UP       = 8'had;
	localparam logic [7:0] KEY_DOWN     = 8'haf;
	localparam logic [7:0] KEY_RIGHT    = 8'hae;
	localparam logic [7:0] KEY_LEFT     = 8'hac;
	localparam logic [7:0] KEY_F1       = 8'h80 + 8'h3b;
	localparam logic [7:0] KEY_F5       = 8'h80 + 8'h3f;
	localparam logic [7:0] KEY_F6       = 8'h80 + 8'h40;
	localparam logic [7:0] KEY_F7       = 8'h80 + 8'h41;
	localparam logic [7:0] KEY_F8       = 8'h80 + 8'h42;
	localparam logic [7:0] KEY_F9       = 8'h80 + 8'h43;
	localparam logic [7:0] KEY_F10      = 8'h80 + 8'h44;
	localparam logic [7:0] KEY_F11      = 8'h80 + 8'h57;
	localparam logic [7:0] KEY_F12      = 8'h80 + 8'h58;
	localparam logic [7:0] KEY_CTRL_R   = 8'h80 + 8'h1d;
	localparam logic [7:0] KEY_ALT_R    = 8'h80 + 8'h38;
	localparam logic [7:0] KEY_ESC_CODE = 8'h1b;

	typedef struct packed {
		logic [7:0]             code;
		logic [STAMP_WIDTH-1:0] stamp;
	} key_entry_t;

	typedef struct packed {
		logic valid;
		logic full;
	} queue_status_t;

endpackage

// ===== rtl/core/tkd_front.sv =====
// Front end of the key decoder: escape sequence parser and character mapping.
// Accepts terminal bytes and pushes each decoded key with its timestamp into the queue.
// Depends on tkd_pkg.
module tkd_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   rx_byte,
	input  logic [tkd_pkg::STAMP_WIDTH-1:0] arrival_time,
	input  tkd_pkg::queue_status_t       q_status,
	output logic                         push,
	output tkd_pkg::key_entry_t          push_entry
);
	import tkd_pkg::*;

	phase_t     phase_q;
	phase_t     phase_next;
	logic       accept;
	logic       hit;
	logic [7:0] code;

	assign in_stall = q_status.full;
	assign accept   = in_valid & ~q_status.full;

	always_comb begin
		phase_next = PH_IDLE;
		case (phase_q)
			PH_IDLE: begin
				if (rx_byte == CH_ESC) begin
					phase_next = PH_ESC;
				end
			end
			PH_ESC: begin
				if (rx_byte == CH_LBRACKET) begin
					phase_next = PH_CSI;
				end else if (rx_byte == CH_UPPER_O) begin
					phase_next = PH_SS3;
				end else begin
					phase_next = PH_SWALLOW;
				end
			end
			PH_CSI: begin
				if (rx_byte == CH_DIGIT_1) begin
					phase_next = PH_CSI1;
				end else if (rx_byte == CH_DIGIT_2) begin
					phase_next = PH_CSI2;
				end
			end
			PH_CSI1: phase_next = PH_SWALLOW;
			PH_CSI2: phase_next = PH_SWALLOW;
			default: phase_next = PH_IDLE;
		endcase
	end

	always_comb begin
		hit  = 1'b0;
		code = '0;
		case (phase_q)
			PH_IDLE: begin
				if (rx_byte != CH_ESC) begin
					hit = 1'b1;
					if (rx_byte == CH_LOWER_A || rx_byte == CH_UPPER_A) begin
						code = KEY_CTRL_R;
					end else if (rx_byte == CH_LOWER_Z || rx_byte == CH_UPPER_Z) begin
						code = KEY_ALT_R;
					end else if (rx_byte == CH_LOWER_P || rx_byte == CH_UPPER_P) begin
						code = KEY_ESC_CODE;
					end else if (rx_byte >= CH_UPPER_A && rx_byte <= CH_UPPER_Z) begin
						code = rx_byte + CASE_OFFSET;
					end else begin
						code = rx_byte;
					end
				end
			end
			PH_CSI: begin
				hit = 1'b1;
				case (rx_byte)
					CH_UPPER_A: code = KEY_UP;
					CH_UPPER_B: code = KEY_DOWN;
					CH_UPPER_C: code = KEY_RIGHT;
					CH_UPPER_D: code = KEY_LEFT;
					default:    hit  = 1'b0;
				endcase
			end
			PH_CSI1: begin
				hit = 1'b1;
				case (rx_byte)
					CH_DIGIT_5: code = KEY_F5;
					CH_DIGIT_7: code = KEY_F6;
					CH_DIGIT_8: code = KEY_F7;
					CH_DIGIT_9: code = KEY_F8;
					default:    hit  = 1'b0;
				endcase
			end
			PH_CSI2: begin
				hit = 1'b1;
				case (rx_byte)
					CH_DIGIT_0: code = KEY_F9;
					CH_DIGIT_1: code = KEY_F10;
					CH_DIGIT_2: code = KEY_F11;
					CH_DIGIT_4: code = KEY_F12;
					default:    hit  = 1'b0;
				endcase
			end
			PH_SS3: begin
				if (rx_byte >= CH_UPPER_P && rx_byte <= CH_UPPER_S) begin
					hit  = 1'b1;
					code = KEY_F1 + (rx_byte - CH_UPPER_P);
				end
			end
			default: begin
				hit  = 1'b0;
				code = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (accept) begin
			phase_q <= phase_next;
		end
	end

	assign push             = accept & hit;
	assign push_entry.code  = code;
	assign push_entry.stamp = arrival_time;

endmodule

// ===== rtl/core/tkd_queue.sv =====
// Short first-in first-out queue of decoded keys between the front and back ends.
// Register based; reports valid and full as a status struct.
// Depends on tkd_pkg.
module tkd_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  tkd_pkg::key_entry_t    push_entry,
	input  logic                   pop,
	output tkd_pkg::key_entry_t    head,
	output tkd_pkg::queue_status_t status
);
	import tkd_pkg::*;

	localparam int PtrWidth   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CountWidth = $clog2(QUEUE_DEPTH + 1);

	key_entry_t            slot_q [QUEUE_DEPTH];
	logic [PtrWidth-1:0]   wr_ptr_q;
	logic [PtrWidth-1:0]   rd_ptr_q;
	logic [CountWidth-1:0] count_q;

	function automatic logic [PtrWidth-1:0] ptr_inc(input logic [PtrWidth-1:0] ptr);
		logic [PtrWidth-1:0] res;
		if (ptr == PtrWidth'(QUEUE_DEPTH - 1)) begin
			res = '0;
		end else begin
			res = ptr + 1'b1;
		end
		return res;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head         = slot_q[rd_ptr_q];
	assign status.valid = (count_q != '0);
	assign status.full  = (count_q == CountWidth'(QUEUE_DEPTH));

endmodule

// ===== rtl/core/tkd_back.sv =====
// Back end of the key decoder: held key tracking and event output register.
// Emits a key-up of the held key where needed, then the key-down of each queued key.
// Depends on tkd_pkg.
module tkd_back #(
	parameter int TIME_WIDTH = tkd_pkg::TIME_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tkd_pkg::key_entry_t           head,
	input  tkd_pkg::queue_status_t        q_status,
	output logic                          pop,
	input  logic [tkd_pkg::GAP_WIDTH-1:0] release_gap,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    key_code,
	output logic                          is_release,
	output logic                          last
);
	import tkd_pkg::*;

	localparam int WideWidth = (TIME_WIDTH > STAMP_WIDTH) ? TIME_WIDTH : STAMP_WIDTH;
	localparam int CmpWidth  = (WideWidth > GAP_WIDTH) ? WideWidth : GAP_WIDTH;

	logic                  out_valid_q;
	logic [7:0]            key_code_q;
	logic                  is_release_q;
	logic                  last_q;
	logic                  pend_q;
	logic [7:0]            pend_code_q;
	logic                  held_valid_q;
	logic [7:0]            held_key_q;
	logic [TIME_WIDTH-1:0] held_time_q;

	logic                  load;
	logic [WideWidth-1:0]  stamp_wide;
	logic [TIME_WIDTH-1:0] now;
	logic [TIME_WIDTH-1:0] gap;
	logic                  need_release;

	assign load       = ~out_valid_q | ~out_stall;
	assign stamp_wide = WideWidth'(head.stamp);
	assign now        = stamp_wide[TIME_WIDTH-1:0];
	assign gap        = now - held_time_q;
	assign need_release = held_valid_q &&
		((head.code != held_key_q) || (CmpWidth'(gap) > CmpWidth'(release_gap)));
	assign pop        = load & ~pend_q & q_status.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_q       <= 1'b0;
			held_valid_q <= 1'b0;
			held_key_q   <= '0;
			held_time_q  <= '0;
		end else if (load) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else if (q_status.valid) begin
				out_valid_q  <= 1'b1;
				pend_q       <= need_release;
				held_valid_q <= 1'b1;
				held_key_q   <= head.code;
				held_time_q  <= now;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				key_code_q   <= pend_code_q;
				is_release_q <= 1'b0;
				last_q       <= 1'b1;
			end else if (need_release) begin
				key_code_q   <= held_key_q;
				is_release_q <= 1'b1;
				last_q       <= 1'b0;
				pend_code_q  <= head.code;
			end else begin
				key_code_q   <= head.code;
				is_release_q <= 1'b0;
				last_q       <= 1'b1;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign key_code   = key_code_q;
	assign is_release = is_release_q;
	assign last       = last_q;

endmodule

// ===== rtl/core/terminal_key_event_decoder_core.sv =====
// Terminal key event decoder, top level: front end, key queue and back end.
// A byte is written into the key queue, then its first event into the event output register.
// Throughput: one byte per cycle while the queue is not full; a byte that releases a held key
// yields a key-up, then a key-down, through the single event output register of the back end.
// Reset clears the parser, the queue, the held key and sets the release gap to 250.
module terminal_key_event_decoder_core #(
	parameter int TIME_WIDTH = tkd_pkg::TIME_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tkd_pkg::GAP_WIDTH-1:0]   cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      rx_byte,
	input  logic [tkd_pkg::STAMP_WIDTH-1:0] arrival_time,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      key_code,
	output logic                            is_release,
	output logic                            last
);
	import tkd_pkg::*;

	logic [GAP_WIDTH-1:0] release_gap_q;
	logic                 push;
	key_entry_t           push_entry;
	logic                 pop;
	key_entry_t           head;
	queue_status_t        q_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			release_gap_q <= RELEASE_GAP_RST;
		end else if (cfg_we) begin
			release_gap_q <= cfg_wdata;
		end
	end

	tkd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.arrival_time (arrival_time),
		.q_status     (q_status),
		.push         (push),
		.push_entry   (push_entry)
	);

	tkd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	tkd_back #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_status    (q_status),
		.pop         (pop),
		.release_gap (release_gap_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.key_code    (key_code),
		.is_release  (is_release),
		.last        (last)
	);

endmodule
